### src/assert_macros.svh
// Assertion macros shared by the gamepad velocity block.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/gtvc_pkg.sv
// Types, constants and helper functions for the gamepad velocity block.
// Depends on nothing; used by every module of the block.
package gtvc_pkg;

  // Arithmetic widths; the rounded dividend never exceeds 48 bits.
  localparam int AccW = 48;
  localparam int QuoW = 32;
  localparam int QuoLsb = 16;
  localparam int MulAW = 35;
  localparam int MulBW = 16;
  localparam int DivCntW = 5;
  localparam logic [DivCntW-1:0] DivLast = 5'd31;
  localparam int RoundShift = 15;

  localparam logic [8:0] ScaleOne = 9'd256;
  localparam logic [11:0] MultReset = 12'd256;
  localparam logic [31:0] PosLimit = 32'd8388607;
  localparam logic [31:0] NegLimit = 32'd8388608;
  localparam logic [23:0] PosSat = 24'h7FFFFF;
  localparam logic [23:0] NegSat = 24'h800000;

  // Register reset values.
  localparam logic [8:0] DeadZoneReset = 9'd32;
  localparam logic [15:0] MaxSpeedReset = 16'd2560;
  localparam logic [8:0] FineScaleReset = 9'd64;
  localparam logic [7:0] MultStepReset = 8'd26;
  localparam logic [11:0] MultMinReset = 12'd26;
  localparam logic [11:0] MultMaxReset = 12'd768;
  localparam logic [9:0] TrigThreshReset = 10'd512;

  typedef enum logic [2:0] {
    REG_DEAD_ZONE         = 3'd0,
    REG_MAX_SPEED         = 3'd1,
    REG_FINE_SCALE        = 3'd2,
    REG_MULT_STEP         = 3'd3,
    REG_MULT_MIN          = 3'd4,
    REG_MULT_MAX          = 3'd5,
    REG_TRIGGER_THRESHOLD = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [8:0]  dead_zone;
    logic [15:0] max_speed;
    logic [8:0]  fine_scale;
    logic [7:0]  mult_step;
    logic [11:0] mult_min;
    logic [11:0] mult_max;
    logic [9:0]  trigger_threshold;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_A, S_MUL_S, S_MUL_M, S_ROUND, S_DIV, S_SAT, S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_MUL_A, OP_MUL_S, OP_MUL_M, OP_ROUND, OP_DIV, OP_SAT
  } dp_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic   capture;
    dp_op_t op;
    logic   axis_sel;
    logic   load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  // Step a multiplier up, clamped at the maximum.
  function automatic logic [11:0] mult_up(input logic [11:0] m, input logic [7:0] step,
                                          input logic [11:0] mx);
    logic [12:0] v;
    v = {1'b0, m} + {5'd0, step};
    return (v < {1'b0, mx}) ? v[11:0] : mx;
  endfunction

  // Step a multiplier down, clamped at the minimum without wrapping.
  function automatic logic [11:0] mult_down(input logic [11:0] m, input logic [7:0] step,
                                            input logic [11:0] mn);
    logic signed [13:0] v;
    v = $signed({2'b00, m}) - $signed({6'd0, step});
    return (v > $signed({2'b00, mn})) ? v[11:0] : mn;
  endfunction

endpackage

### src/gtvc_regs.sv
// APB configuration registers of the gamepad velocity block.
// Depends on gtvc_pkg for the register map and the configuration struct.
module gtvc_regs (
  input  logic            clk,
  input  logic            rst,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output gtvc_pkg::cfg_t  cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dead_zone         <= gtvc_pkg::DeadZoneReset;
      cfg.max_speed         <= gtvc_pkg::MaxSpeedReset;
      cfg.fine_scale        <= gtvc_pkg::FineScaleReset;
      cfg.mult_step         <= gtvc_pkg::MultStepReset;
      cfg.mult_min          <= gtvc_pkg::MultMinReset;
      cfg.mult_max          <= gtvc_pkg::MultMaxReset;
      cfg.trigger_threshold <= gtvc_pkg::TrigThreshReset;
    end else if (wr_en) begin
      unique case (idx)
        gtvc_pkg::REG_DEAD_ZONE:         cfg.dead_zone <= pwdata[8:0];
        gtvc_pkg::REG_MAX_SPEED:         cfg.max_speed <= pwdata[15:0];
        gtvc_pkg::REG_FINE_SCALE:        cfg.fine_scale <= pwdata[8:0];
        gtvc_pkg::REG_MULT_STEP:         cfg.mult_step <= pwdata[7:0];
        gtvc_pkg::REG_MULT_MIN:          cfg.mult_min <= pwdata[11:0];
        gtvc_pkg::REG_MULT_MAX:          cfg.mult_max <= pwdata[11:0];
        gtvc_pkg::REG_TRIGGER_THRESHOLD: cfg.trigger_threshold <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (idx)
      gtvc_pkg::REG_DEAD_ZONE:         prdata = 32'(cfg.dead_zone);
      gtvc_pkg::REG_MAX_SPEED:         prdata = 32'(cfg.max_speed);
      gtvc_pkg::REG_FINE_SCALE:        prdata = 32'(cfg.fine_scale);
      gtvc_pkg::REG_MULT_STEP:         prdata = 32'(cfg.mult_step);
      gtvc_pkg::REG_MULT_MIN:          prdata = 32'(cfg.mult_min);
      gtvc_pkg::REG_MULT_MAX:          prdata = 32'(cfg.mult_max);
      gtvc_pkg::REG_TRIGGER_THRESHOLD: prdata = 32'(cfg.trigger_threshold);
      default:                         prdata = 32'd0;
    endcase
  end

endmodule

### src/gtvc_dp.sv
// Datapath: frame capture, shared multiplier, bit-serial divider, button state, output beat.
// Depends on gtvc_pkg and assert_macros.svh; driven by gtvc_ctrl.
`include "assert_macros.svh"

module gtvc_dp #(
  parameter int STICK_FULL_SCALE = 512
) (
  input  logic                  clk,
  input  logic                  rst,
  input  gtvc_pkg::cfg_t        cfg,
  input  gtvc_pkg::dp_cmd_t     cmd,
  output gtvc_pkg::dp_stat_t    stat,
  input  logic signed [9:0]     stick_x,
  input  logic signed [9:0]     stick_y,
  input  logic [9:0]            trigger_level,
  input  logic                  fine_hold,
  input  logic                  latch_button,
  input  logic                  stop_button,
  input  logic                  estop_button,
  input  logic                  home_button,
  input  logic [3:0]            dpad_bits,
  input  logic                  menu_button,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [23:0]    pan_velocity,
  output logic signed [23:0]    tilt_velocity,
  output logic                  laser_on,
  output logic                  stop_pulse,
  output logic                  estop_pulse,
  output logic                  home_pulse,
  output logic                  limits_toggle_pulse
);

  localparam int DW = $clog2(STICK_FULL_SCALE + 1);
  localparam int RW = DW + 1;
  localparam logic [16:0] FullExt = 17'(STICK_FULL_SCALE);

  // Captured frame.
  logic signed [9:0] sx, sy;
  logic [9:0]        trig;
  logic              fine;
  logic [3:0]        btn, dpad;
  logic              menu;

  // State kept across frames.
  logic [3:0]  last_buttons, last_dpad;
  logic        last_menu;
  logic [11:0] pan_mult, tilt_mult;
  logic        laser_latched, strobe_phase;

  // Arithmetic registers.
  logic [gtvc_pkg::AccW-1:0] acc;
  logic [RW-1:0]             rem;
  logic signed [23:0]        pan_vel, tilt_vel;

  // Per-axis operand selection.
  logic signed [9:0]          raw;
  logic                       raw_neg, raw_pos;
  logic [9:0]                 mag_abs, above;
  logic [16:0]                dz_ext, d_full;
  logic                       zero_axis;
  logic [DW-1:0]              div_d;
  logic [8:0]                 scale;
  logic [11:0]                mult;
  logic [gtvc_pkg::MulAW-1:0] mul_a;
  logic [gtvc_pkg::MulBW-1:0] mul_b;
  logic [gtvc_pkg::MulAW+gtvc_pkg::MulBW-1:0] product;
  logic [RW-1:0]              rem_sh, rem_sub;
  logic                       ge;
  logic [gtvc_pkg::AccW-1:0]  round_add;
  logic [gtvc_pkg::QuoW-1:0]  quo;
  logic [23:0]                qs_pos, vel_pos, vel_neg;
  logic signed [23:0]         vel;

  // Frame-end update values.
  logic [3:0]  rose, drose;
  logic        mrose, held, sp_next, latch_next;
  logic [11:0] pan_m1, pan_m2, tilt_m1, tilt_m2;

  assign raw     = cmd.axis_sel ? sy : sx;
  assign raw_neg = raw[9];
  assign raw_pos = !raw_neg && (raw != 10'sd0);
  assign mag_abs = raw_neg ? (~raw + 10'd1) : raw;
  assign above   = mag_abs - {1'b0, cfg.dead_zone};
  assign dz_ext  = {8'd0, cfg.dead_zone};
  assign d_full  = FullExt - dz_ext;
  assign div_d   = d_full[DW-1:0];
  assign zero_axis = (mag_abs < {1'b0, cfg.dead_zone}) || (dz_ext >= FullExt);
  assign scale   = fine ? cfg.fine_scale : gtvc_pkg::ScaleOne;
  assign mult    = cmd.axis_sel ? tilt_mult : pan_mult;

  // Shared multiplier: stick excursion, then speed, then scale, then multiplier.
  always_comb begin
    case (cmd.op)
      gtvc_pkg::OP_MUL_A: begin
        mul_a = gtvc_pkg::MulAW'(above);
        mul_b = cfg.max_speed;
      end
      gtvc_pkg::OP_MUL_S: begin
        mul_a = acc[gtvc_pkg::MulAW-1:0];
        mul_b = gtvc_pkg::MulBW'(scale);
      end
      default: begin
        mul_a = acc[gtvc_pkg::MulAW-1:0];
        mul_b = gtvc_pkg::MulBW'(mult);
      end
    endcase
  end
  assign product = mul_a * mul_b;

  // One restoring-division step; the quotient bits shift into the accumulator.
  assign rem_sh    = {rem[RW-2:0], acc[gtvc_pkg::AccW-1]};
  assign ge        = rem_sh >= {1'b0, div_d};
  assign rem_sub   = rem_sh - {1'b0, div_d};
  assign round_add = gtvc_pkg::AccW'(div_d) << gtvc_pkg::RoundShift;
  assign quo       = acc[gtvc_pkg::AccW-1:gtvc_pkg::QuoLsb];

  // Saturation and sign: a positive stick gives a negative velocity.
  assign qs_pos  = (quo > gtvc_pkg::NegLimit) ? gtvc_pkg::NegSat : quo[23:0];
  assign vel_pos = ~qs_pos + 24'd1;
  assign vel_neg = (quo > gtvc_pkg::PosLimit) ? gtvc_pkg::PosSat : quo[23:0];
  always_comb begin
    if (zero_axis) begin
      vel = 24'sd0;
    end else if (raw_pos) begin
      vel = $signed(vel_pos);
    end else begin
      vel = $signed(vel_neg);
    end
  end

  // Frame capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sx   <= stick_x;
      sy   <= stick_y;
      trig <= trigger_level;
      fine <= fine_hold;
      btn  <= {home_button, estop_button, stop_button, latch_button};
      dpad <= dpad_bits;
      menu <= menu_button;
    end
  end

  // Arithmetic sequence for one axis.
  always_ff @(posedge clk) begin
    case (cmd.op) inside
      gtvc_pkg::OP_MUL_A, gtvc_pkg::OP_MUL_S, gtvc_pkg::OP_MUL_M: begin
        acc <= product[gtvc_pkg::AccW-1:0];
      end
      gtvc_pkg::OP_ROUND: begin
        acc <= acc + round_add;
        rem <= '0;
      end
      gtvc_pkg::OP_DIV: begin
        acc <= {acc[gtvc_pkg::AccW-2:gtvc_pkg::QuoLsb], ge, gtvc_pkg::QuoLsb'(0)};
        rem <= ge ? rem_sub : rem_sh;
      end
      gtvc_pkg::OP_SAT: begin
        if (cmd.axis_sel) begin
          tilt_vel <= vel;
        end else begin
          pan_vel <= vel;
        end
      end
      default: ;
    endcase
  end

  // Edge detection, multiplier steps and laser logic for the frame end.
  assign rose  = btn & ~last_buttons;
  assign drose = dpad & ~last_dpad;
  assign mrose = menu & ~last_menu;
  assign pan_m1  = drose[2] ? gtvc_pkg::mult_up(pan_mult, cfg.mult_step, cfg.mult_max)
                            : pan_mult;
  assign pan_m2  = drose[3] ? gtvc_pkg::mult_down(pan_m1, cfg.mult_step, cfg.mult_min)
                            : pan_m1;
  assign tilt_m1 = drose[0] ? gtvc_pkg::mult_up(tilt_mult, cfg.mult_step, cfg.mult_max)
                            : tilt_mult;
  assign tilt_m2 = drose[1] ? gtvc_pkg::mult_down(tilt_m1, cfg.mult_step, cfg.mult_min)
                            : tilt_m1;
  assign held       = trig > cfg.trigger_threshold;
  assign sp_next    = held && !strobe_phase;
  assign latch_next = laser_latched ^ rose[0];

  // Persistent state, updated once per frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_buttons  <= '0;
      last_dpad     <= '0;
      last_menu     <= 1'b0;
      pan_mult      <= gtvc_pkg::MultReset;
      tilt_mult     <= gtvc_pkg::MultReset;
      laser_latched <= 1'b0;
      strobe_phase  <= 1'b0;
    end else if (cmd.load_out) begin
      last_buttons  <= btn;
      last_dpad     <= dpad;
      last_menu     <= menu;
      pan_mult      <= pan_m2;
      tilt_mult     <= tilt_m2;
      laser_latched <= latch_next;
      strobe_phase  <= sp_next;
    end
  end

  // Output beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pan_velocity        <= pan_vel;
      tilt_velocity       <= tilt_vel;
      laser_on            <= latch_next || (held && sp_next);
      stop_pulse          <= rose[1];
      estop_pulse         <= rose[2];
      home_pulse          <= rose[3];
      limits_toggle_pulse <= mrose;
    end
  end

  assign stat.out_free = !out_valid || !out_stall;

  `ASSERT_NEXT(a_load_sets_valid, clk, rst, cmd.load_out, out_valid)
  `ASSERT_NEXT(a_zero_pan, clk, rst,
    cmd.op == gtvc_pkg::OP_SAT && !cmd.axis_sel && zero_axis, pan_vel == 24'sd0)
  `ASSERT_NEXT(a_mult_hold, clk, rst, !cmd.load_out,
    $stable(pan_mult) && $stable(tilt_mult))

endmodule

### src/gtvc_ctrl.sv
// Controller state machine that sequences the datapath through one frame.
// Depends on gtvc_pkg and assert_macros.svh; drives gtvc_dp.
`include "assert_macros.svh"

module gtvc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  gtvc_pkg::dp_stat_t     stat,
  output gtvc_pkg::dp_cmd_t      cmd
);

  gtvc_pkg::state_t state, state_next;
  logic                          axis, axis_next;
  logic [gtvc_pkg::DivCntW-1:0]  cnt, cnt_next;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gtvc_pkg::S_IDLE;
      axis  <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      cnt   <= cnt_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next   = state;
    axis_next    = axis;
    cnt_next     = cnt;
    in_stall     = 1'b1;
    cmd.capture  = 1'b0;
    cmd.op       = gtvc_pkg::OP_NONE;
    cmd.axis_sel = axis;
    cmd.load_out = 1'b0;
    unique case (state)
      gtvc_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          axis_next   = 1'b0;
          state_next  = gtvc_pkg::S_MUL_A;
        end
      end
      gtvc_pkg::S_MUL_A: begin
        cmd.op     = gtvc_pkg::OP_MUL_A;
        state_next = gtvc_pkg::S_MUL_S;
      end
      gtvc_pkg::S_MUL_S: begin
        cmd.op     = gtvc_pkg::OP_MUL_S;
        state_next = gtvc_pkg::S_MUL_M;
      end
      gtvc_pkg::S_MUL_M: begin
        cmd.op     = gtvc_pkg::OP_MUL_M;
        state_next = gtvc_pkg::S_ROUND;
      end
      gtvc_pkg::S_ROUND: begin
        cmd.op     = gtvc_pkg::OP_ROUND;
        cnt_next   = '0;
        state_next = gtvc_pkg::S_DIV;
      end
      gtvc_pkg::S_DIV: begin
        cmd.op   = gtvc_pkg::OP_DIV;
        cnt_next = cnt + 1'b1;
        if (cnt == gtvc_pkg::DivLast) begin
          state_next = gtvc_pkg::S_SAT;
        end
      end
      gtvc_pkg::S_SAT: begin
        cmd.op = gtvc_pkg::OP_SAT;
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = gtvc_pkg::S_MUL_A;
        end else begin
          state_next = gtvc_pkg::S_FINISH;
        end
      end
      gtvc_pkg::S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = gtvc_pkg::S_IDLE;
        end
      end
      default: state_next = gtvc_pkg::S_IDLE;
    endcase
  end

  `ASSERT_NEXT(a_capture_starts, clk, rst, cmd.capture, state == gtvc_pkg::S_MUL_A)
  `ASSERT_IMPLY(a_sat_after_div, clk, rst, state == gtvc_pkg::S_SAT,
    $past(state) == gtvc_pkg::S_DIV && $past(cnt) == gtvc_pkg::DivLast)
  `ASSERT_IMPLY(a_load_when_free, clk, rst, cmd.load_out, stat.out_free)

endmodule

### src/gamepad_to_velocity_commands.sv
// Top level of the gamepad to pan/tilt velocity command block.
// Depends on gtvc_pkg, gtvc_regs, gtvc_ctrl and gtvc_dp.
//
// One gamepad frame is taken per input beat and gives one result beat. From acceptance
// to the next acceptance a frame runs a capture, then per axis three multiplies on a
// shared 35x16 multiplier, one rounding add and a 32-step bit-serial divider, plus one
// saturation step, and finally a load of the output register. The divider, run once
// per axis, dominates the frame time. A result waiting in the output register does not
// hold up the next frame's computation; only the final load waits for the output to be
// taken. The user must write configuration over the APB port only while the block is
// idle; the block itself does not enforce this.
module gamepad_to_velocity_commands #(
  parameter int STICK_FULL_SCALE = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [9:0]  stick_x,
  input  logic signed [9:0]  stick_y,
  input  logic [9:0]         trigger_level,
  input  logic               fine_hold,
  input  logic               latch_button,
  input  logic               stop_button,
  input  logic               estop_button,
  input  logic               home_button,
  input  logic [3:0]         dpad_bits,
  input  logic               menu_button,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] pan_velocity,
  output logic signed [23:0] tilt_velocity,
  output logic               laser_on,
  output logic               stop_pulse,
  output logic               estop_pulse,
  output logic               home_pulse,
  output logic               limits_toggle_pulse,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  gtvc_pkg::cfg_t     cfg;
  gtvc_pkg::dp_cmd_t  cmd;
  gtvc_pkg::dp_stat_t stat;

  // Configuration registers.
  gtvc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Frame sequencer.
  gtvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic and per-frame state.
  gtvc_dp #(
    .STICK_FULL_SCALE (STICK_FULL_SCALE)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cfg                 (cfg),
    .cmd                 (cmd),
    .stat                (stat),
    .stick_x             (stick_x),
    .stick_y             (stick_y),
    .trigger_level       (trigger_level),
    .fine_hold           (fine_hold),
    .latch_button        (latch_button),
    .stop_button         (stop_button),
    .estop_button        (estop_button),
    .home_button         (home_button),
    .dpad_bits           (dpad_bits),
    .menu_button         (menu_button),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .pan_velocity        (pan_velocity),
    .tilt_velocity       (tilt_velocity),
    .laser_on            (laser_on),
    .stop_pulse          (stop_pulse),
    .estop_pulse         (estop_pulse),
    .home_pulse          (home_pulse),
    .limits_toggle_pulse (limits_toggle_pulse)
  );

endmodule
